@@ src/chained_trilinear_color_poly_core_macros.svh @@
// assertion macros shared by the color polynomial chain
`ifndef CHAINED_TRILINEAR_COLOR_POLY_CORE_MACROS_SVH
`define CHAINED_TRILINEAR_COLOR_POLY_CORE_MACROS_SVH

// same-cycle implication
`define CTCP_ASSERT_NOW(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CTCP_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

@@ src/ctcp_pkg.sv @@
// shared types and constants for the chained color polynomial pipeline
package ctcp_pkg;

    localparam int MAX_STAGES  = 8;
    localparam int SAMPLE_BITS = 24;
    localparam int FRAC_BITS   = 20;
    localparam int CHANNELS    = 3;
    localparam int CORNERS     = 8;
    localparam int TERMS       = CORNERS * CHANNELS;

    localparam int SIDX_W = (MAX_STAGES > 8) ? $clog2(MAX_STAGES) : 3;
    localparam int ACC_W  = ((4 * SAMPLE_BITS > SAMPLE_BITS + 3 * FRAC_BITS) ?
                             4 * SAMPLE_BITS : SAMPLE_BITS + 3 * FRAC_BITS) + 4;

    // corner numbers, term index is corner * CHANNELS + channel
    localparam int CORNER_OFFSET = 0;
    localparam int CORNER_X      = 1;
    localparam int CORNER_XY     = 4;
    localparam int CORNER_XYZ    = 7;

    typedef enum logic [1:0] {
        OP_WR_COEF   = 2'd0,
        OP_WR_MASK   = 2'd1,
        OP_TRANSFORM = 2'd2,
        OP_NOP       = 2'd3
    } op_t;

    typedef logic signed [SAMPLE_BITS-1:0]   sample_t;
    typedef logic signed [2*SAMPLE_BITS-1:0] prod_t;
    typedef logic signed [2*SAMPLE_BITS:0]   prodx_t;
    typedef logic signed [ACC_W-1:0]         acc_t;

    localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam acc_t    ROUND_BIAS = acc_t'(1) << (3 * FRAC_BITS - 1);

    typedef struct packed {
        op_t                operation;
        logic [2:0]         stage_index;
        logic [4:0]         coeff_index;
        sample_t            coeff_value;
        logic [TERMS-1:0]   enable_mask;
        sample_t            in_x;
        sample_t            in_y;
        sample_t            in_z;
    } req_t;

    typedef struct packed {
        sample_t out_x;
        sample_t out_y;
        sample_t out_z;
        logic    saturated;
    } rsp_t;

    typedef struct packed {
        req_t req;
        logic sat;
    } item_t;

endpackage

@@ src/chained_trilinear_color_poly_core.sv @@
// top level: config register, stage chain and result register
// throughput: one transaction per cycle while no result is held under stall, set by the fully pipelined stage chain
// every stage takes eight register levels whether or not it is applied
// the whole chain halts while a result is held under stall
// reset clears valids, enable masks and stage_count; coefficients are undefined until written
module chained_trilinear_color_poly_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  ctcp_pkg::req_t    req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output ctcp_pkg::rsp_t    rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int NST    = ctcp_pkg::MAX_STAGES;
    localparam int SIDX_W = ctcp_pkg::SIDX_W;
    localparam logic REG_STAGE_COUNT = 1'b0;

    logic            adv;
    logic [3:0]      stage_count_reg;
    logic            rsp_valid_reg;
    ctcp_pkg::rsp_t  rsp_reg;
    logic            valid_w [NST+1];
    ctcp_pkg::item_t item_w  [NST+1];
    logic            cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_STAGE_COUNT);
    assign prdata = (paddr[2] == REG_STAGE_COUNT) ? {28'd0, stage_count_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_count_reg <= '0;
        end
        else if (cfg_wr)
        begin
            stage_count_reg <= pwdata[3:0];
        end
    end

    assign adv       = !(rsp_valid_reg && rsp_stall);
    assign req_stall = !adv;

    assign valid_w[0]    = req_valid;
    assign item_w[0].req = req;
    assign item_w[0].sat = 1'b0;

    for (genvar i = 0; i < NST; i++)
    begin : g_stage
        logic active;
        assign active = int'(stage_count_reg) > i;
        ctcp_stage u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .stage_id (SIDX_W'(i)),
            .active   (active),
            .up_valid (valid_w[i]),
            .up_item  (item_w[i]),
            .dn_valid (valid_w[i+1]),
            .dn_item  (item_w[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            rsp_valid_reg <= valid_w[NST] &&
                             (item_w[NST].req.operation == ctcp_pkg::OP_TRANSFORM);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rsp_reg.out_x     <= item_w[NST].req.in_x;
            rsp_reg.out_y     <= item_w[NST].req.in_y;
            rsp_reg.out_z     <= item_w[NST].req.in_z;
            rsp_reg.saturated <= item_w[NST].sat;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ src/ctcp_stage.sv @@
// one polynomial stage: coefficient store and eight-register arithmetic pipeline
`include "chained_trilinear_color_poly_core_macros.svh"

module ctcp_stage (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic [ctcp_pkg::SIDX_W-1:0]   stage_id,
    input  logic                          active,
    input  logic                          up_valid,
    input  ctcp_pkg::item_t               up_item,
    output logic                          dn_valid,
    output ctcp_pkg::item_t               dn_item
);

    localparam int SW   = ctcp_pkg::SAMPLE_BITS;
    localparam int FW   = ctcp_pkg::FRAC_BITS;
    localparam int T    = ctcp_pkg::TERMS;
    localparam int NCH  = ctcp_pkg::CHANNELS;
    localparam int SIDX_W = ctcp_pkg::SIDX_W;
    localparam int A_W  = ctcp_pkg::ACC_W;
    localparam int L_W  = 2 * SW + 2;
    localparam int X_W  = 3 * SW;
    localparam int Q_W  = 3 * SW + 3;

    // coefficient store and enable mask
    ctcp_pkg::sample_t coef_mem [T];
    logic [T-1:0]      mask_reg;
    ctcp_pkg::sample_t gate [T];
    logic              wr_hit;

    // pipeline registers
    logic              v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg;
    logic              a1_reg, a2_reg, a3_reg, a4_reg, a5_reg, a6_reg, a7_reg;
    ctcp_pkg::item_t   it1_reg, it2_reg, it3_reg, it4_reg, it5_reg, it6_reg, it7_reg, it8_reg;
    ctcp_pkg::item_t   it8_next;
    ctcp_pkg::sample_t g1_reg [T];
    ctcp_pkg::sample_t g2_reg [T];
    ctcp_pkg::sample_t g3_reg [T];
    ctcp_pkg::sample_t g4_reg [T];

    ctcp_pkg::prod_t   pr_next [3];
    ctcp_pkg::prod_t   pr2_reg [3];
    ctcp_pkg::prod_t   lin_next [NCH][3];
    ctcp_pkg::prod_t   lin2_reg [NCH][3];

    ctcp_pkg::prodx_t  pzlo_next, pzlo3_reg;
    ctcp_pkg::prod_t   pzhi_next, pzhi3_reg;
    logic signed [L_W-1:0] lsum_next [NCH];
    logic signed [L_W-1:0] l3_reg [NCH];
    logic signed [L_W-1:0] l4_reg [NCH];
    ctcp_pkg::prodx_t  qlo_next [NCH][3];
    ctcp_pkg::prodx_t  qlo3_reg [NCH][3];
    ctcp_pkg::prod_t   qhi_next [NCH][3];
    ctcp_pkg::prod_t   qhi3_reg [NCH][3];

    logic signed [X_W-1:0] xyz_next, xyz4_reg;
    logic signed [Q_W-1:0] q_next [NCH];
    logic signed [Q_W-1:0] q4_reg [NCH];

    ctcp_pkg::prodx_t  pc0_next [NCH];
    ctcp_pkg::prodx_t  pc1_next [NCH];
    ctcp_pkg::prod_t   pc2_next [NCH];
    ctcp_pkg::prodx_t  pc0_5_reg [NCH];
    ctcp_pkg::prodx_t  pc1_5_reg [NCH];
    ctcp_pkg::prod_t   pc2_5_reg [NCH];
    ctcp_pkg::acc_t    p_next [NCH];
    ctcp_pkg::acc_t    p5_reg [NCH];
    ctcp_pkg::acc_t    p6_reg [NCH];
    ctcp_pkg::acc_t    cub_next [NCH];
    ctcp_pkg::acc_t    cub6_reg [NCH];
    ctcp_pkg::acc_t    sum_next [NCH];
    ctcp_pkg::acc_t    sum7_reg [NCH];

    assign wr_hit = adv && up_valid &&
                    (SIDX_W'(up_item.req.stage_index) == stage_id);

    always_ff @(posedge clk)
    begin
        if (wr_hit && (up_item.req.operation == ctcp_pkg::OP_WR_COEF) &&
            (int'(up_item.req.coeff_index) < T))
        begin
            coef_mem[up_item.req.coeff_index] <= up_item.req.coeff_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else if (wr_hit && (up_item.req.operation == ctcp_pkg::OP_WR_MASK))
        begin
            mask_reg <= up_item.req.enable_mask;
        end
    end

    always_comb
    begin
        for (int k = 0; k < T; k++)
        begin
            gate[k] = mask_reg[k] ? coef_mem[k] : '0;
        end
    end

    // stage 2 products: pair products and linear terms
    always_comb
    begin
        pr_next[0] = it1_reg.req.in_x * it1_reg.req.in_y;
        pr_next[1] = it1_reg.req.in_x * it1_reg.req.in_z;
        pr_next[2] = it1_reg.req.in_y * it1_reg.req.in_z;
        for (int c = 0; c < NCH; c++)
        begin
            lin_next[c][0] = g1_reg[(ctcp_pkg::CORNER_X + 0) * NCH + c] * it1_reg.req.in_x;
            lin_next[c][1] = g1_reg[(ctcp_pkg::CORNER_X + 1) * NCH + c] * it1_reg.req.in_y;
            lin_next[c][2] = g1_reg[(ctcp_pkg::CORNER_X + 2) * NCH + c] * it1_reg.req.in_z;
        end
    end

    // stage 3 products: xyz halves, pair terms split in halves, linear sum
    always_comb
    begin
        pzlo_next = $signed({1'b0, pr2_reg[0][SW-1:0]}) * it2_reg.req.in_z;
        pzhi_next = $signed(pr2_reg[0][2*SW-1:SW]) * it2_reg.req.in_z;
        for (int c = 0; c < NCH; c++)
        begin
            lsum_next[c] = L_W'(lin2_reg[c][0]) + L_W'(lin2_reg[c][1]) + L_W'(lin2_reg[c][2]);
            for (int m = 0; m < 3; m++)
            begin
                qlo_next[c][m] = $signed({1'b0, pr2_reg[m][SW-1:0]}) *
                                 g2_reg[(ctcp_pkg::CORNER_XY + m) * NCH + c];
                qhi_next[c][m] = $signed(pr2_reg[m][2*SW-1:SW]) *
                                 g2_reg[(ctcp_pkg::CORNER_XY + m) * NCH + c];
            end
        end
    end

    // stage 4: recombine halves
    always_comb
    begin
        xyz_next = (X_W'(pzhi3_reg) <<< SW) + X_W'(pzlo3_reg);
        for (int c = 0; c < NCH; c++)
        begin
            q_next[c] = (Q_W'(qhi3_reg[c][0]) <<< SW) + Q_W'(qlo3_reg[c][0])
                      + (Q_W'(qhi3_reg[c][1]) <<< SW) + Q_W'(qlo3_reg[c][1])
                      + (Q_W'(qhi3_reg[c][2]) <<< SW) + Q_W'(qlo3_reg[c][2]);
        end
    end

    // stage 5: cubic partial products and aligned lower-order sum
    always_comb
    begin
        for (int c = 0; c < NCH; c++)
        begin
            pc0_next[c] = $signed({1'b0, xyz4_reg[SW-1:0]}) *
                          g4_reg[ctcp_pkg::CORNER_XYZ * NCH + c];
            pc1_next[c] = $signed({1'b0, xyz4_reg[2*SW-1:SW]}) *
                          g4_reg[ctcp_pkg::CORNER_XYZ * NCH + c];
            pc2_next[c] = $signed(xyz4_reg[3*SW-1:2*SW]) *
                          g4_reg[ctcp_pkg::CORNER_XYZ * NCH + c];
            p_next[c]   = (A_W'(g4_reg[ctcp_pkg::CORNER_OFFSET * NCH + c]) <<< (3 * FW))
                        + (A_W'(l4_reg[c]) <<< (2 * FW))
                        + (A_W'(q4_reg[c]) <<< FW)
                        + ctcp_pkg::ROUND_BIAS;
        end
    end

    // stage 6 and 7: cubic term, then total
    always_comb
    begin
        for (int c = 0; c < NCH; c++)
        begin
            cub_next[c] = (A_W'(pc2_5_reg[c]) <<< (2 * SW))
                        + (A_W'(pc1_5_reg[c]) <<< SW)
                        + A_W'(pc0_5_reg[c]);
            sum_next[c] = p6_reg[c] + cub6_reg[c];
        end
    end

    // stage 8: round by truncation of biased sum, saturate; only active transforms take the result
    always_comb
    begin
        logic [A_W-3*FW-SW:0] top;
        logic                 ovf;
        logic                 clip_any;
        ctcp_pkg::sample_t    res [NCH];
        clip_any = 1'b0;
        for (int c = 0; c < NCH; c++)
        begin
            top = sum7_reg[c][A_W-1:3*FW+SW-1];
            ovf = !((&top) || !(|top));
            if (ovf)
            begin
                res[c] = sum7_reg[c][A_W-1] ? ctcp_pkg::SAMPLE_MIN : ctcp_pkg::SAMPLE_MAX;
            end
            else
            begin
                res[c] = sum7_reg[c][3*FW+SW-1:3*FW];
            end
            clip_any = clip_any | ovf;
        end
        it8_next = it7_reg;
        if (a7_reg && (it7_reg.req.operation == ctcp_pkg::OP_TRANSFORM))
        begin
            it8_next.req.in_x = res[0];
            it8_next.req.in_y = res[1];
            it8_next.req.in_z = res[2];
            it8_next.sat      = it7_reg.sat | clip_any;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0; v2_reg <= 1'b0; v3_reg <= 1'b0; v4_reg <= 1'b0;
            v5_reg <= 1'b0; v6_reg <= 1'b0; v7_reg <= 1'b0; v8_reg <= 1'b0;
            a1_reg <= 1'b0; a2_reg <= 1'b0; a3_reg <= 1'b0; a4_reg <= 1'b0;
            a5_reg <= 1'b0; a6_reg <= 1'b0; a7_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= up_valid; v2_reg <= v1_reg; v3_reg <= v2_reg; v4_reg <= v3_reg;
            v5_reg <= v4_reg;   v6_reg <= v5_reg; v7_reg <= v6_reg; v8_reg <= v7_reg;
            a1_reg <= active;   a2_reg <= a1_reg; a3_reg <= a2_reg; a4_reg <= a3_reg;
            a5_reg <= a4_reg;   a6_reg <= a5_reg; a7_reg <= a6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            it1_reg <= up_item; it2_reg <= it1_reg; it3_reg <= it2_reg; it4_reg <= it3_reg;
            it5_reg <= it4_reg; it6_reg <= it5_reg; it7_reg <= it6_reg; it8_reg <= it8_next;
            g1_reg <= gate; g2_reg <= g1_reg; g3_reg <= g2_reg; g4_reg <= g3_reg;
            pr2_reg   <= pr_next;
            lin2_reg  <= lin_next;
            pzlo3_reg <= pzlo_next;
            pzhi3_reg <= pzhi_next;
            l3_reg    <= lsum_next;
            l4_reg    <= l3_reg;
            qlo3_reg  <= qlo_next;
            qhi3_reg  <= qhi_next;
            xyz4_reg  <= xyz_next;
            q4_reg    <= q_next;
            pc0_5_reg <= pc0_next;
            pc1_5_reg <= pc1_next;
            pc2_5_reg <= pc2_next;
            p5_reg    <= p_next;
            p6_reg    <= p5_reg;
            cub6_reg  <= cub_next;
            sum7_reg  <= sum_next;
        end
    end

    assign dn_valid = v8_reg;
    assign dn_item  = it8_reg;

    `CTCP_ASSERT_NEXT(a_sat_sticky, adv && v7_reg && it7_reg.sat, it8_reg.sat, "saturation flag lost in stage")
    `CTCP_ASSERT_NEXT(a_bypass, adv && v7_reg && !a7_reg, (it8_reg.req.in_x == $past(it7_reg.req.in_x)) && (it8_reg.req.in_z == $past(it7_reg.req.in_z)), "inactive stage changed color")
    `CTCP_ASSERT_NEXT(a_hold, !adv && v8_reg, v8_reg && $stable(it8_reg), "stage output moved while halted")

endmodule
